// ----- sv/epst_pkg.sv -----
// Shared types and constants for the epoch / super-epoch tracker.
// Used by epst_ctrl, epst_dp and epoch_super_epoch_tracker_core; no dependencies.
package epst_pkg;

  // Default sizing
  localparam int NUM_BOARDS_DEF  = 4;
  localparam int NUM_SOURCES_DEF = 8;
  localparam int EPOCH_BITS_DEF  = 12;

  // Fixed field widths of the stream words
  localparam int ID_W     = 16;
  localparam int SRC_W    = 3;
  localparam int EPOCH_W  = 12;
  localparam int SUPER_W  = 32;
  localparam int STATUS_W = 3;
  localparam int IN_DATA_W  = 32;  // 16 + 3 + 12 = 31, padded to bytes
  localparam int OUT_DATA_W = 48;  // 12 + 32 + 3 = 47, padded to bytes

  // Configuration
  localparam int ID_REGS     = 4;
  localparam int SLOT_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ID3      = 3'd4;

  localparam int BACKSTEP_LIMIT = 3000;

  // Item function
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WRAP       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SUPPRESSED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDENTICAL  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd5;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch input word and issue table read
    logic commit;   // evaluate, write tables, load result register
  } ctrl_cmd_t;

endpackage

// ----- sv/epst_ctrl.sv -----
// Controller of the epoch tracker: two-state sequencer and result-valid flag.
// Depends on epst_pkg.
module epst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output epst_pkg::ctrl_cmd_t cmd
);
  import epst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  // load the result only when the output register is free or being drained
  assign cmd.commit  = (state_r == S_CALC) && (!out_vld_r || out_tready);
  assign out_tvalid  = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_CALC;
      end
      S_CALC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.commit) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_CALC))
    else $error("accepted word did not enter evaluation");
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_vld_r && state_r == S_IDLE))
    else $error("committed result not presented");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC && !cmd.commit) |=> (state_r == S_CALC && out_vld_r))
    else $error("evaluation left while output register full");
`endif
endmodule

// ----- sv/epst_dp.sv -----
// Datapath of the epoch tracker: config registers, slot match, per-source tables,
// wrap detection and the result register. Depends on epst_pkg.
module epst_dp #(
  parameter int NUM_BOARDS  = epst_pkg::NUM_BOARDS_DEF,
  parameter int NUM_SOURCES = epst_pkg::NUM_SOURCES_DEF,
  parameter int EPOCH_BITS  = epst_pkg::EPOCH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  epst_pkg::ctrl_cmd_t               cmd,
  input  logic                              cfg_we,
  input  logic [epst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_func,
  input  logic [epst_pkg::ID_W-1:0]         in_equipment_id,
  input  logic [epst_pkg::SRC_W-1:0]        in_source_index,
  input  logic [epst_pkg::EPOCH_W-1:0]      in_rx_epoch,
  output logic [epst_pkg::EPOCH_W-1:0]      out_epoch_value,
  output logic [epst_pkg::SUPER_W-1:0]      out_super_epoch_value,
  output logic [epst_pkg::STATUS_W-1:0]     out_status
);
  import epst_pkg::*;

  localparam int DEPTH = NUM_BOARDS * NUM_SOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = AW + SLOT_W + 5;
  localparam int EW    = EPOCH_BITS;
  localparam int CMPW  = ((EW > EPOCH_W) ? EW : EPOCH_W) + 1;
  localparam logic [CMPW-1:0] EP_MASK = CMPW'((65'd1 << EW) - 65'd1);

  // Configuration registers
  logic                suppress_r;
  logic [ID_W-1:0]     eq_id_r [ID_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      suppress_r <= 1'b0;
      for (int i = 0; i < ID_REGS; i++) eq_id_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUPPRESS: suppress_r <= cfg_wdata[0];
        REG_ID0:      eq_id_r[0] <= cfg_wdata;
        REG_ID1:      eq_id_r[1] <= cfg_wdata;
        REG_ID2:      eq_id_r[2] <= cfg_wdata;
        REG_ID3:      eq_id_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Slot match, lowest slot wins
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic [IW-1:0]     idx_wide;
  logic [AW-1:0]     rd_addr;
  logic              known;

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int s = ID_REGS - 1; s >= 0; s--) begin
      if (s < NUM_BOARDS && eq_id_r[s] == in_equipment_id) begin
        hit  = 1'b1;
        slot = SLOT_W'(s);
      end
    end
    known    = hit && ({2'b00, in_source_index} < 5'(NUM_SOURCES));
    idx_wide = IW'(slot) * IW'(NUM_SOURCES) + IW'(in_source_index);
    rd_addr  = known ? idx_wide[AW-1:0] : '0;
  end

  // Per-source tables; valid bits stand in for the all-zero reset
  logic [EW-1:0]      epoch_mem [DEPTH];
  logic [EW-1:0]      prev_mem  [DEPTH];
  logic [SUPER_W-1:0] super_mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;

  // Captured item and read data
  logic               func_r, known_r, rd_vld_r;
  logic [AW-1:0]      idx_r;
  logic [EW-1:0]      ep_r, rd_epoch_r, rd_prev_r;
  logic [SUPER_W-1:0] rd_super_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_func;
      known_r    <= known;
      idx_r      <= rd_addr;
      ep_r       <= EW'(CMPW'(in_rx_epoch) & EP_MASK);
      rd_epoch_r <= epoch_mem[rd_addr];
      rd_prev_r  <= prev_mem[rd_addr];
      rd_super_r <= super_mem[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
    end
  end

  // Evaluate
  logic [CMPW-1:0]     ep_x, stored_x, prev_x;
  logic [SUPER_W-1:0]  super_cur, super_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic                do_write;
  logic [CMPW-1:0]     epoch_after;

  always_comb begin
    ep_x       = CMPW'(ep_r);
    stored_x   = rd_vld_r ? CMPW'(rd_epoch_r) : '0;
    prev_x     = rd_vld_r ? CMPW'(rd_prev_r) : '0;
    super_cur  = rd_vld_r ? rd_super_r : '0;
    super_nxt  = super_cur;
    status_nxt = ST_OK;
    if (ep_x + CMPW'(BACKSTEP_LIMIT) < stored_x) begin
      if (suppress_r && ep_x == prev_x) begin
        status_nxt = ST_SUPPRESSED;
      end else begin
        super_nxt  = super_cur + SUPER_W'(1);
        status_nxt = ST_WRAP;
      end
    end else if (ep_x == stored_x) begin
      status_nxt = ST_IDENTICAL;
    end else if (ep_x != stored_x + CMPW'(1)) begin
      status_nxt = ST_MISSED;
    end
    do_write    = known_r && (func_r == FUNC_UPDATE);
    epoch_after = do_write ? ep_x : stored_x;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) begin
      epoch_mem[idx_r] <= ep_r;
      prev_mem[idx_r]  <= stored_x[EW-1:0];
      super_mem[idx_r] <= super_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.commit && do_write) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // Result register
  logic [EPOCH_W-1:0]  res_epoch_r;
  logic [SUPER_W-1:0]  res_super_r;
  logic [STATUS_W-1:0] res_status_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!known_r) begin
        res_epoch_r  <= '0;
        res_super_r  <= '0;
        res_status_r <= ST_UNKNOWN;
      end else if (func_r == FUNC_LOOKUP) begin
        res_epoch_r  <= epoch_after[EPOCH_W-1:0];
        res_super_r  <= super_cur;
        res_status_r <= ST_OK;
      end else begin
        res_epoch_r  <= epoch_after[EPOCH_W-1:0];
        res_super_r  <= super_nxt;
        res_status_r <= status_nxt;
      end
    end
  end

  assign out_epoch_value       = res_epoch_r;
  assign out_super_epoch_value = res_super_r;
  assign out_status            = res_status_r;

`ifndef SYNTHESIS
  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && do_write) |=> vld_r[$past(idx_r)])
    else $error("table entry written but not marked valid");
  a_wrap_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && known_r && func_r == FUNC_UPDATE && status_nxt == ST_WRAP)
      |=> (out_super_epoch_value == $past(super_cur) + SUPER_W'(1)))
    else $error("counted wrap did not advance super epoch");
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !known_r) |=> (out_status == ST_UNKNOWN && out_epoch_value == '0))
    else $error("unknown link result not cleared");
`endif
endmodule

// ----- sv/epoch_super_epoch_tracker_core.sv -----
// Epoch / super-epoch tracker top level: stream ports, controller and datapath.
// An accepted word is captured with its table read; once the result register is free
// it is evaluated, written back and loaded there. No new word is taken meanwhile.
// The output register lets the next word be accepted while a result waits.
// Reset (rst_n, synchronous, active low) clears config and marks all table entries zero.
// Depends on epst_pkg, epst_ctrl, epst_dp.
module epoch_super_epoch_tracker_core #(
  parameter int NUM_BOARDS  = epst_pkg::NUM_BOARDS_DEF,
  parameter int NUM_SOURCES = epst_pkg::NUM_SOURCES_DEF,
  parameter int EPOCH_BITS  = epst_pkg::EPOCH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [epst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input word stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] equipment_id, [18:16] source_index, [30:19] received epoch, [31] zero
  input  logic [epst_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] func
  input  logic                              in_tuser,
  // result word stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [11:0] epoch_value, [43:12] super_epoch_value, [46:44] status, [47] zero
  output logic [epst_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import epst_pkg::*;

  ctrl_cmd_t cmd;

  logic [EPOCH_W-1:0]  epoch_value;
  logic [SUPER_W-1:0]  super_epoch_value;
  logic [STATUS_W-1:0] status;

  // Sequencer: accept in idle, evaluate next cycle, hold while output is full
  epst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Tables and arithmetic; unpack the input word here
  epst_dp #(
    .NUM_BOARDS  (NUM_BOARDS),
    .NUM_SOURCES (NUM_SOURCES),
    .EPOCH_BITS  (EPOCH_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_func               (in_tuser),
    .in_equipment_id       (in_tdata[15:0]),
    .in_source_index       (in_tdata[18:16]),
    .in_rx_epoch           (in_tdata[30:19]),
    .out_epoch_value       (epoch_value),
    .out_super_epoch_value (super_epoch_value),
    .out_status            (status)
  );

  // Pack the result word, pad bit is zero
  assign out_tdata = {1'b0, status, super_epoch_value, epoch_value};

endmodule
